// File: hdl/row_peak_ridge_tracker_unit_macros.svh
// Assertion macros for the ridge tracker. Both expect clk_i and rst_ni in scope.
`ifndef ROW_PEAK_RIDGE_TRACKER_UNIT_MACROS_SVH
`define ROW_PEAK_RIDGE_TRACKER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RPRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RPRT_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define RPRT_ASSERT(label, prop, msg)
`define RPRT_ASSERT_NEVER(label, expr, msg)
`endif
`endif

// File: hdl/rprt_pkg.sv
`default_nettype none

package rprt_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COL_W    = 10;
  localparam int unsigned ROW_W    = 12;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned SUM_W    = 28;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  localparam int unsigned MAX_COLS = 1024;
  localparam int unsigned MAX_ROWS = 4096;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLS - 1);
  localparam logic [LEN_W-1:0] LEN_MAX  = {LEN_W{1'b1}};

  localparam logic signed [SUM_W-1:0] SUM_HI = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_LO = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic signed [SAMPLE_W-1:0] THRESH_RST  = 16'sd3277;
  localparam logic [LEN_W-1:0]           MIN_LEN_RST = 13'd3;
  localparam logic [COL_W-1:0]           JUMP_RST    = 10'd2;

  typedef enum logic [ADDR_W-3:0] {
    REG_THRESH   = 2'd0,
    REG_MIN_LEN  = 2'd1,
    REG_MAX_JUMP = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] thresh;
    logic [LEN_W-1:0]           min_len;
    logic [COL_W-1:0]           max_jump;
  } cfg_t;

  typedef struct packed {
    logic smp_acc;
    logic row_eval;
    logic frame_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic brk_res;
    logic fin_res;
    logic div_busy;
  } sts_t;

endpackage

`default_nettype wire

// File: hdl/row_peak_ridge_tracker_unit.sv
// Samples inside a row are taken one word per cycle.
// Row-end sample with no ridge reported: ST_ROW, then ST_FRAME, then the next word.
// Each reported ridge adds a run of the bit-serial average divider plus any output
// stall; ST_DIV loads its word, after ST_ROW on a break, after ST_FRAME at frame end.
// Reset (rst_ni low, async) clears counters, ridge state and pending results and
// loads the registers with their defaults.
`default_nettype none
`include "row_peak_ridge_tracker_unit_macros.svh"

module row_peak_ridge_tracker_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [rprt_pkg::ADDR_W-1:0]           paddr,
  input  logic [rprt_pkg::DATA_W-1:0]           pwdata,
  output logic [rprt_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [rprt_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                  row_end_i,
  input  logic                                  frame_end_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [rprt_pkg::ROW_W-1:0]            start_row_o,
  output logic [rprt_pkg::COL_W-1:0]            start_col_o,
  output logic [rprt_pkg::ROW_W-1:0]            end_row_o,
  output logic [rprt_pkg::COL_W-1:0]            end_col_o,
  output logic [rprt_pkg::LEN_W-1:0]            ridge_length_o,
  output logic signed [rprt_pkg::SAMPLE_W-1:0]  peak_amplitude_o,
  output logic signed [rprt_pkg::SAMPLE_W-1:0]  average_amplitude_o,
  output logic                                  last_o
);

  logic signed [rprt_pkg::SAMPLE_W-1:0] thresh_q, thresh_d;
  logic [rprt_pkg::LEN_W-1:0]           min_len_q, min_len_d;
  logic [rprt_pkg::COL_W-1:0]           max_jump_q, max_jump_d;

  rprt_pkg::reg_idx_e reg_idx;
  logic               wr_en;
  rprt_pkg::cfg_t     cfg;
  rprt_pkg::cmd_t     cmd;
  rprt_pkg::sts_t     sts;

  assign pready  = 1'b1;
  assign reg_idx = rprt_pkg::reg_idx_e'(paddr[rprt_pkg::ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    thresh_d   = thresh_q;
    min_len_d  = min_len_q;
    max_jump_d = max_jump_q;
    prdata     = '0;
    unique case (reg_idx)
      rprt_pkg::REG_THRESH: begin
        prdata = rprt_pkg::DATA_W'(thresh_q);
        if (wr_en) begin
          thresh_d = $signed(pwdata[rprt_pkg::SAMPLE_W-1:0]);
        end
      end
      rprt_pkg::REG_MIN_LEN: begin
        prdata = rprt_pkg::DATA_W'(min_len_q);
        if (wr_en) begin
          min_len_d = pwdata[rprt_pkg::LEN_W-1:0];
        end
      end
      rprt_pkg::REG_MAX_JUMP: begin
        prdata = rprt_pkg::DATA_W'(max_jump_q);
        if (wr_en) begin
          max_jump_d = pwdata[rprt_pkg::COL_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q   <= rprt_pkg::THRESH_RST;
      min_len_q  <= rprt_pkg::MIN_LEN_RST;
      max_jump_q <= rprt_pkg::JUMP_RST;
    end else begin
      thresh_q   <= thresh_d;
      min_len_q  <= min_len_d;
      max_jump_q <= max_jump_d;
    end
  end

  // zero in either limit behaves as one
  always_comb begin
    cfg.thresh   = thresh_q;
    cfg.min_len  = (min_len_q == '0) ? rprt_pkg::LEN_W'(1) : min_len_q;
    cfg.max_jump = (max_jump_q == '0) ? rprt_pkg::COL_W'(1) : max_jump_q;
  end

  rprt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .row_end_i   (row_end_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rprt_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .cfg_i               (cfg),
    .sts_o               (sts),
    .sample_i            (sample_i),
    .row_end_i           (row_end_i),
    .frame_end_i         (frame_end_i),
    .start_row_o         (start_row_o),
    .start_col_o         (start_col_o),
    .end_row_o           (end_row_o),
    .end_col_o           (end_col_o),
    .ridge_length_o      (ridge_length_o),
    .peak_amplitude_o    (peak_amplitude_o),
    .average_amplitude_o (average_amplitude_o),
    .last_o              (last_o)
  );

  `RPRT_ASSERT(a_load_div_done, cmd.load_out |-> !sts.div_busy, "word loaded before divide done")
  `RPRT_ASSERT(a_load_no_overwrite, cmd.load_out |-> (!out_valid_o || out_ready_i), "output word overwritten")
  `RPRT_ASSERT_NEVER(a_accept_div_idle, in_valid_i && in_ready_o && sts.div_busy, "sample taken while dividing")
  `RPRT_ASSERT(a_row_after_end, cmd.row_eval |-> $past(in_valid_i && in_ready_o && row_end_i), "row step without row end")

endmodule

`default_nettype wire

// File: hdl/rprt_div.sv
`default_nettype none

// signed / unsigned, one quotient bit per cycle, truncates toward zero
module rprt_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [rprt_pkg::SUM_W-1:0]     dividend_i,
  input  logic [rprt_pkg::LEN_W-1:0]            divisor_i,
  output logic                                  busy_o,
  output logic signed [rprt_pkg::SAMPLE_W-1:0]  quot_o
);

  localparam int unsigned SW   = rprt_pkg::SUM_W;
  localparam int unsigned LW   = rprt_pkg::LEN_W;
  localparam int unsigned QW   = rprt_pkg::SAMPLE_W;
  localparam int unsigned CNTW = $clog2(SW);

  localparam logic signed [SW:0] Q_HI = {{(SW+2-QW){1'b0}}, {(QW-1){1'b1}}};
  localparam logic signed [SW:0] Q_LO = {{(SW+2-QW){1'b1}}, {(QW-1){1'b0}}};

  logic            busy_q, busy_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            neg_q, neg_d;
  logic [LW-1:0]   dvs_q, dvs_d;
  logic [LW:0]     rem_q, rem_d;
  logic [SW-1:0]   quo_q, quo_d;

  logic [LW:0]     shifted;
  logic            ge;
  logic signed [SW:0] sq;

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    shifted = {rem_q[LW-1:0], quo_q[SW-1]};
    ge      = shifted >= {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNTW'(SW - 1);
      neg_d  = dividend_i[SW-1];
      dvs_d  = divisor_i;
      rem_d  = '0;
      quo_d  = dividend_i[SW-1] ? (~dividend_i + 1'b1) : dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? (shifted - {1'b0, dvs_q}) : shifted;
      quo_d = {quo_q[SW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    neg_q <= neg_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  always_comb begin
    sq = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    if (sq > Q_HI) begin
      quot_o = $signed(Q_HI[QW-1:0]);
    end else if (sq < Q_LO) begin
      quot_o = $signed(Q_LO[QW-1:0]);
    end else begin
      quot_o = $signed(sq[QW-1:0]);
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

// File: hdl/rprt_dp.sv
`default_nettype none

module rprt_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rprt_pkg::cmd_t                        cmd_i,
  input  rprt_pkg::cfg_t                        cfg_i,
  output rprt_pkg::sts_t                        sts_o,
  input  logic signed [rprt_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                  row_end_i,
  input  logic                                  frame_end_i,
  output logic [rprt_pkg::ROW_W-1:0]            start_row_o,
  output logic [rprt_pkg::COL_W-1:0]            start_col_o,
  output logic [rprt_pkg::ROW_W-1:0]            end_row_o,
  output logic [rprt_pkg::COL_W-1:0]            end_col_o,
  output logic [rprt_pkg::LEN_W-1:0]            ridge_length_o,
  output logic signed [rprt_pkg::SAMPLE_W-1:0]  peak_amplitude_o,
  output logic signed [rprt_pkg::SAMPLE_W-1:0]  average_amplitude_o,
  output logic                                  last_o
);

  localparam int unsigned SW = rprt_pkg::SAMPLE_W;
  localparam int unsigned CW = rprt_pkg::COL_W;
  localparam int unsigned RW = rprt_pkg::ROW_W;
  localparam int unsigned LW = rprt_pkg::LEN_W;
  localparam int unsigned UW = rprt_pkg::SUM_W;

  // row scan
  logic signed [SW-1:0] row_max_q, row_max_d;
  logic [CW-1:0]        row_max_col_q, row_max_col_d;
  logic [CW-1:0]        col_cnt_q, col_cnt_d;
  logic                 row_started_q, row_started_d;
  logic                 frame_end_q, frame_end_d;
  logic [RW-1:0]        row_cnt_q, row_cnt_d;

  // open ridge
  logic                 ridge_open_q, ridge_open_d;
  logic [RW-1:0]        open_start_row_q, open_start_row_d;
  logic [CW-1:0]        open_start_col_q, open_start_col_d;
  logic [CW-1:0]        prev_col_q, prev_col_d;
  logic signed [SW-1:0] open_peak_q, open_peak_d;
  logic signed [UW-1:0] open_sum_q, open_sum_d;
  logic [LW-1:0]        open_len_q, open_len_d;

  // closed ridge waiting for its average
  logic [RW-1:0]        res_start_row_q, res_start_row_d;
  logic [CW-1:0]        res_start_col_q, res_start_col_d;
  logic [RW-1:0]        res_end_row_q, res_end_row_d;
  logic [CW-1:0]        res_end_col_q, res_end_col_d;
  logic [LW-1:0]        res_len_q, res_len_d;
  logic signed [SW-1:0] res_peak_q, res_peak_d;
  logic                 res_last_q, res_last_d;

  // output word
  logic [RW-1:0]        o_start_row_q, o_start_row_d;
  logic [CW-1:0]        o_start_col_q, o_start_col_d;
  logic [RW-1:0]        o_end_row_q, o_end_row_d;
  logic [CW-1:0]        o_end_col_q, o_end_col_d;
  logic [LW-1:0]        o_len_q, o_len_d;
  logic signed [SW-1:0] o_peak_q, o_peak_d;
  logic signed [SW-1:0] o_avg_q, o_avg_d;
  logic                 o_last_q, o_last_d;

  logic                 peak;
  logic [CW-1:0]        col_dist;
  logic                 cont;
  logic                 long_enough;
  logic signed [UW:0]   sum_ext;
  logic signed [UW-1:0] sum_sat;
  logic [LW-1:0]        len_inc;
  logic                 open_after_row;
  logic [LW-1:0]        len_after_row;
  logic                 fin_row;
  logic                 fin_frm;
  logic                 brk_res;
  logic                 div_start;
  logic                 div_busy;
  logic signed [SW-1:0] div_quot;

  always_comb begin
    peak = row_max_q >= cfg_i.thresh;
    col_dist = (row_max_col_q > prev_col_q) ? (row_max_col_q - prev_col_q)
                                            : (prev_col_q - row_max_col_q);
    cont        = ridge_open_q && peak && (col_dist <= cfg_i.max_jump);
    long_enough = open_len_q >= cfg_i.min_len;
    sum_ext = $signed({open_sum_q[UW-1], open_sum_q})
            + $signed({{(UW+1-SW){row_max_q[SW-1]}}, row_max_q});
    if (sum_ext[UW] != sum_ext[UW-1]) begin
      sum_sat = sum_ext[UW] ? rprt_pkg::SUM_LO : rprt_pkg::SUM_HI;
    end else begin
      sum_sat = $signed(sum_ext[UW-1:0]);
    end
    len_inc        = (open_len_q == rprt_pkg::LEN_MAX) ? open_len_q : (open_len_q + 1'b1);
    open_after_row = cont || peak;
    len_after_row  = cont ? len_inc : LW'(1);
    fin_row = frame_end_q && open_after_row && (len_after_row >= cfg_i.min_len);
    fin_frm = frame_end_q && ridge_open_q && long_enough;
    brk_res = ridge_open_q && !cont && long_enough;
  end

  assign div_start = (cmd_i.row_eval && brk_res) || (cmd_i.frame_step && fin_frm);

  always_comb begin
    row_max_d        = row_max_q;
    row_max_col_d    = row_max_col_q;
    col_cnt_d        = col_cnt_q;
    row_started_d    = row_started_q;
    frame_end_d      = frame_end_q;
    row_cnt_d        = row_cnt_q;
    ridge_open_d     = ridge_open_q;
    open_start_row_d = open_start_row_q;
    open_start_col_d = open_start_col_q;
    prev_col_d       = prev_col_q;
    open_peak_d      = open_peak_q;
    open_sum_d       = open_sum_q;
    open_len_d       = open_len_q;
    res_start_row_d  = res_start_row_q;
    res_start_col_d  = res_start_col_q;
    res_end_row_d    = res_end_row_q;
    res_end_col_d    = res_end_col_q;
    res_len_d        = res_len_q;
    res_peak_d       = res_peak_q;
    res_last_d       = res_last_q;
    o_start_row_d    = o_start_row_q;
    o_start_col_d    = o_start_col_q;
    o_end_row_d      = o_end_row_q;
    o_end_col_d      = o_end_col_q;
    o_len_d          = o_len_q;
    o_peak_d         = o_peak_q;
    o_avg_d          = o_avg_q;
    o_last_d         = o_last_q;

    if (cmd_i.smp_acc) begin
      if (!row_started_q || (sample_i > row_max_q)) begin
        row_max_d     = sample_i;
        row_max_col_d = col_cnt_q;
      end
      row_started_d = 1'b1;
      frame_end_d   = frame_end_i;
      if (!row_end_i && (col_cnt_q != rprt_pkg::COL_LAST)) begin
        col_cnt_d = col_cnt_q + 1'b1;
      end
    end

    if (cmd_i.row_eval) begin
      col_cnt_d     = '0;
      row_started_d = 1'b0;
      if (brk_res) begin
        res_start_row_d = open_start_row_q;
        res_start_col_d = open_start_col_q;
        res_end_row_d   = row_cnt_q - 1'b1;
        res_end_col_d   = prev_col_q;
        res_len_d       = open_len_q;
        res_peak_d      = open_peak_q;
        res_last_d      = !fin_row;
      end
      if (cont) begin
        if (row_max_q > open_peak_q) begin
          open_peak_d = row_max_q;
        end
        open_sum_d = sum_sat;
        open_len_d = len_inc;
        prev_col_d = row_max_col_q;
      end else begin
        ridge_open_d = peak;
        if (peak) begin
          open_start_row_d = row_cnt_q;
          open_start_col_d = row_max_col_q;
          prev_col_d       = row_max_col_q;
          open_peak_d      = row_max_q;
          open_sum_d       = $signed({{(UW-SW){row_max_q[SW-1]}}, row_max_q});
          open_len_d       = LW'(1);
        end
      end
    end

    if (cmd_i.frame_step) begin
      if (frame_end_q) begin
        if (fin_frm) begin
          res_start_row_d = open_start_row_q;
          res_start_col_d = open_start_col_q;
          res_end_row_d   = row_cnt_q;
          res_end_col_d   = prev_col_q;
          res_len_d       = open_len_q;
          res_peak_d      = open_peak_q;
          res_last_d      = 1'b1;
        end
        ridge_open_d = 1'b0;
        row_cnt_d    = '0;
      end else begin
        row_cnt_d = row_cnt_q + 1'b1;
      end
    end

    if (cmd_i.load_out) begin
      o_start_row_d = res_start_row_q;
      o_start_col_d = res_start_col_q;
      o_end_row_d   = res_end_row_q;
      o_end_col_d   = res_end_col_q;
      o_len_d       = res_len_q;
      o_peak_d      = res_peak_q;
      o_avg_d       = div_quot;
      o_last_d      = res_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q     <= '0;
      row_started_q <= 1'b0;
      frame_end_q   <= 1'b0;
      row_cnt_q     <= '0;
      ridge_open_q  <= 1'b0;
    end else begin
      col_cnt_q     <= col_cnt_d;
      row_started_q <= row_started_d;
      frame_end_q   <= frame_end_d;
      row_cnt_q     <= row_cnt_d;
      ridge_open_q  <= ridge_open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_max_q        <= row_max_d;
    row_max_col_q    <= row_max_col_d;
    open_start_row_q <= open_start_row_d;
    open_start_col_q <= open_start_col_d;
    prev_col_q       <= prev_col_d;
    open_peak_q      <= open_peak_d;
    open_sum_q       <= open_sum_d;
    open_len_q       <= open_len_d;
    res_start_row_q  <= res_start_row_d;
    res_start_col_q  <= res_start_col_d;
    res_end_row_q    <= res_end_row_d;
    res_end_col_q    <= res_end_col_d;
    res_len_q        <= res_len_d;
    res_peak_q       <= res_peak_d;
    res_last_q       <= res_last_d;
    o_start_row_q    <= o_start_row_d;
    o_start_col_q    <= o_start_col_d;
    o_end_row_q      <= o_end_row_d;
    o_end_col_q      <= o_end_col_d;
    o_len_q          <= o_len_d;
    o_peak_q         <= o_peak_d;
    o_avg_q          <= o_avg_d;
    o_last_q         <= o_last_d;
  end

  rprt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (open_sum_q),
    .divisor_i  (open_len_q),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  always_comb begin
    sts_o.brk_res  = brk_res;
    sts_o.fin_res  = fin_frm;
    sts_o.div_busy = div_busy;
  end

  assign start_row_o         = o_start_row_q;
  assign start_col_o         = o_start_col_q;
  assign end_row_o           = o_end_row_q;
  assign end_col_o           = o_end_col_q;
  assign ridge_length_o      = o_len_q;
  assign peak_amplitude_o    = o_peak_q;
  assign average_amplitude_o = o_avg_q;
  assign last_o              = o_last_q;

endmodule

`default_nettype wire

// File: hdl/rprt_ctrl.sv
`default_nettype none

module rprt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           row_end_i,
  output logic           in_ready_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  input  rprt_pkg::sts_t sts_i,
  output rprt_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROW   = 4'b0010,
    ST_FRAME = 4'b0100,
    ST_DIV   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   ret_frame_q, ret_frame_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    ret_frame_d = ret_frame_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.smp_acc = in_valid_i;
        if (in_valid_i && row_end_i) begin
          state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        cmd_o.row_eval = 1'b1;
        if (sts_i.brk_res) begin
          state_d     = ST_DIV;
          ret_frame_d = 1'b1;
        end else begin
          state_d = ST_FRAME;
        end
      end
      ST_FRAME: begin
        cmd_o.frame_step = 1'b1;
        if (sts_i.fin_res) begin
          state_d     = ST_DIV;
          ret_frame_d = 1'b0;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (!sts_i.div_busy && (!out_valid_q || out_ready_i)) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ret_frame_q ? ST_FRAME : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_frame_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_frame_q <= ret_frame_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: tb/sv/row_peak_ridge_tracker_unit_tb.sv
`timescale 1ns / 1ps

module row_peak_ridge_tracker_unit_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 64;

  typedef struct {
    logic [rprt_pkg::ROW_W-1:0]           start_row;
    logic [rprt_pkg::COL_W-1:0]           start_col;
    logic [rprt_pkg::ROW_W-1:0]           end_row;
    logic [rprt_pkg::COL_W-1:0]           end_col;
    logic [rprt_pkg::LEN_W-1:0]           len;
    logic signed [rprt_pkg::SAMPLE_W-1:0] peak;
    logic signed [rprt_pkg::SAMPLE_W-1:0] avg;
    bit                                   last;
  } ridge_t;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 psel;
  logic                                 penable;
  logic                                 pwrite;
  logic [rprt_pkg::ADDR_W-1:0]          paddr;
  logic [rprt_pkg::DATA_W-1:0]          pwdata;
  logic [rprt_pkg::DATA_W-1:0]          prdata;
  logic                                 pready;
  logic                                 in_valid_i;
  logic                                 in_ready_o;
  logic signed [rprt_pkg::SAMPLE_W-1:0] sample_i;
  logic                                 row_end_i;
  logic                                 frame_end_i;
  logic                                 out_valid_o;
  logic                                 out_ready_i;
  logic [rprt_pkg::ROW_W-1:0]           start_row_o;
  logic [rprt_pkg::COL_W-1:0]           start_col_o;
  logic [rprt_pkg::ROW_W-1:0]           end_row_o;
  logic [rprt_pkg::COL_W-1:0]           end_col_o;
  logic [rprt_pkg::LEN_W-1:0]           ridge_length_o;
  logic signed [rprt_pkg::SAMPLE_W-1:0] peak_amplitude_o;
  logic signed [rprt_pkg::SAMPLE_W-1:0] average_amplitude_o;
  logic                                 last_o;

  row_peak_ridge_tracker_unit dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .sample_i, .row_end_i, .frame_end_i,
    .out_valid_o, .out_ready_i, .start_row_o, .start_col_o, .end_row_o, .end_col_o,
    .ridge_length_o, .peak_amplitude_o, .average_amplitude_o, .last_o
  );

  // shadow config and tracker state
  logic signed [rprt_pkg::SAMPLE_W-1:0] cfg_thresh;
  logic [rprt_pkg::LEN_W-1:0]           cfg_min_len;
  logic [rprt_pkg::COL_W-1:0]           cfg_jump;

  logic signed [rprt_pkg::SAMPLE_W-1:0] trk_row_max;
  logic [rprt_pkg::COL_W-1:0]           trk_row_col;
  logic [rprt_pkg::COL_W-1:0]           trk_col;
  logic [rprt_pkg::ROW_W-1:0]           trk_row;
  bit                                   trk_row_started;
  bit                                   trk_open;
  logic [rprt_pkg::ROW_W-1:0]           trk_start_row;
  logic [rprt_pkg::COL_W-1:0]           trk_start_col;
  logic [rprt_pkg::COL_W-1:0]           trk_prev_col;
  logic signed [rprt_pkg::SAMPLE_W-1:0] trk_peak;
  longint                               trk_sum;
  logic [rprt_pkg::LEN_W-1:0]           trk_len;

  ridge_t pending_ridges[$];
  ridge_t want;
  int     errors;
  int     words_sent;
  int     idle_cycles;
  int     stall_left;
  bit     in_gaps_on;
  bit     out_stall_on;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int close_open_ridge(logic [rprt_pkg::ROW_W-1:0] end_row);
    ridge_t r;
    longint avg;
    logic [rprt_pkg::LEN_W-1:0] min_len;
    int n;
    n = 0;
    min_len = (cfg_min_len == 0) ? rprt_pkg::LEN_W'(1) : cfg_min_len;
    if (trk_open && trk_len >= min_len) begin
      avg = trk_sum / longint'(trk_len);
      if (avg > 32767) avg = 32767;
      if (avg < -32768) avg = -32768;
      r.start_row = trk_start_row;
      r.start_col = trk_start_col;
      r.end_row   = end_row;
      r.end_col   = trk_prev_col;
      r.len       = trk_len;
      r.peak      = trk_peak;
      r.avg       = avg[rprt_pkg::SAMPLE_W-1:0];
      r.last      = 1'b0;
      pending_ridges.push_back(r);
      n = 1;
    end
    trk_open = 0;
    return n;
  endfunction

  function automatic void predict_ridges(logic signed [rprt_pkg::SAMPLE_W-1:0] smp, bit re,
                                         bit fe);
    bit peak;
    int col_step;
    int jump;
    int n;
    n = 0;
    if (!trk_row_started || smp > trk_row_max) begin
      trk_row_max = smp;
      trk_row_col = trk_col;
    end
    trk_row_started = 1;
    if (!re) begin
      if (trk_col != rprt_pkg::COL_LAST) trk_col++;
      return;
    end
    peak = (trk_row_max >= cfg_thresh);
    jump = (cfg_jump == 0) ? 1 : int'(cfg_jump);
    col_step = int'(trk_row_col) - int'(trk_prev_col);
    if (col_step < 0) col_step = -col_step;
    if (trk_open && peak && col_step <= jump) begin
      if (trk_row_max > trk_peak) trk_peak = trk_row_max;
      trk_sum += trk_row_max;
      if (trk_sum > longint'(rprt_pkg::SUM_HI)) trk_sum = rprt_pkg::SUM_HI;
      if (trk_sum < longint'(rprt_pkg::SUM_LO)) trk_sum = rprt_pkg::SUM_LO;
      if (trk_len != rprt_pkg::LEN_MAX) trk_len++;
      trk_prev_col = trk_row_col;
    end else begin
      if (trk_open) n += close_open_ridge(trk_row - 12'd1);
      if (peak) begin
        trk_open      = 1;
        trk_start_row = trk_row;
        trk_start_col = trk_row_col;
        trk_prev_col  = trk_row_col;
        trk_peak      = trk_row_max;
        trk_sum       = trk_row_max;
        trk_len       = 1;
      end
    end
    if (fe) begin
      n += close_open_ridge(trk_row);
      trk_row = 0;
    end else begin
      trk_row++;
    end
    trk_col = 0;
    trk_row_started = 0;
    if (n > 0) pending_ridges[pending_ridges.size()-1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_ridges.size() == 0) begin
        $display("%0t: unexpected ridge word: start_row %0d end_row %0d length %0d",
                 $time, start_row_o, end_row_o, ridge_length_o);
        errors++;
      end else begin
        want = pending_ridges.pop_front();
        check_field("start_row", want.start_row, start_row_o);
        check_field("start_col", want.start_col, start_col_o);
        check_field("end_row", want.end_row, end_row_o);
        check_field("end_col", want.end_col, end_col_o);
        check_field("ridge_length", want.len, ridge_length_o);
        check_field("peak_amplitude", want.peak, peak_amplitude_o);
        check_field("average_amplitude", want.avg, average_amplitude_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog: no handshake for %0d cycles, %0d words pending",
               $time, idle_cycles, pending_ridges.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    out_ready_i = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (out_stall_on && $urandom_range(99) < 15) stall_left = pick_gap();
      end
    end
  end

  task automatic send_word(input logic signed [rprt_pkg::SAMPLE_W-1:0] smp, input bit re,
                           input bit fe);
    int gap;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    sample_i    <= smp;
    row_end_i   <= re;
    frame_end_i <= fe;
    do @(posedge clk_i); while (!in_ready_o);
    predict_ridges(smp, re, fe);
    words_sent++;
  endtask

  task automatic send_row(input int vals[$], input bit fe);
    for (int i = 0; i < vals.size(); i++)
      send_word(vals[i][rprt_pkg::SAMPLE_W-1:0], i == vals.size() - 1,
                fe && (i == vals.size() - 1));
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_ridges.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input rprt_pkg::reg_idx_e idx,
                           input logic [rprt_pkg::DATA_W-1:0] val);
    drain();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    unique case (idx)
      rprt_pkg::REG_THRESH:   cfg_thresh  = val[rprt_pkg::SAMPLE_W-1:0];
      rprt_pkg::REG_MIN_LEN:  cfg_min_len = val[rprt_pkg::LEN_W-1:0];
      rprt_pkg::REG_MAX_JUMP: cfg_jump    = val[rprt_pkg::COL_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input int thr, input int min_len, input int jump);
    write_reg(rprt_pkg::REG_THRESH, thr);
    write_reg(rprt_pkg::REG_MIN_LEN, min_len);
    write_reg(rprt_pkg::REG_MAX_JUMP, jump);
  endtask

  // reset values: exact threshold, tie, jump of 2 continues, sub-threshold row closes
  task automatic test_defaults();
    send_row('{3277, 0, -5}, 0);
    send_row('{-32768, 100, 32767}, 0);
    send_row('{0, 20000, 20000}, 0);
    send_row('{3276, -1, 3276}, 1);
  endtask

  task automatic test_extremes();
    set_config(-32768, 1, 0);
    send_row('{-32768}, 0);
    send_word(16'sd0, 1'b0, 1'b1);
    send_word(16'sh7fff, 1'b1, 1'b0);
    send_row('{-1, -1, 5}, 0);
    // break and frame end on the same row: two words
    send_row('{7, 0, 0}, 1);
    write_reg(rprt_pkg::REG_THRESH, 32767);
    send_row('{32767, 32767}, 1);
    send_row('{32766}, 1);
  endtask

  task automatic send_random_frame();
    int vals[$];
    int rows, ncols, col, val, thr_i;
    rows = $urandom_range(1, 12);
    col  = $urandom_range(0, 7);
    for (int r = 0; r < rows; r++) begin
      if ($urandom_range(99) < 8) begin
        send_word(16'($urandom), $urandom_range(99) < 30, 1'($urandom_range(1)));
        continue;
      end
      ncols = ($urandom_range(99) < 90) ? $urandom_range(1, 10) : $urandom_range(11, 48);
      if ($urandom_range(99) < 10) col = $urandom_range(0, 47);
      else col = col + int'($urandom_range(6)) - 3;
      if (col > ncols - 1) col = ncols - 1;
      if (col < 0) col = 0;
      thr_i = cfg_thresh;
      if ($urandom_range(99) < 80) begin
        val = thr_i + int'($urandom_range(32767 - thr_i));
        if ($urandom_range(9) == 0) val = thr_i;
      end else if (thr_i > -32768) begin
        val = thr_i - 1 - int'($urandom_range(thr_i - 1 + 32768));
      end else begin
        val = -32768 + int'($urandom_range(65535));
      end
      vals.delete();
      for (int c = 0; c < ncols; c++)
        vals.push_back(c == col ? val : -32768 + int'($urandom_range(val + 32768)));
      send_row(vals, r == rows - 1);
    end
  endtask

  task automatic test_random();
    int target;
    for (int phase = 0; phase < 6; phase++) begin
      unique case (phase)
        0: begin set_config($urandom_range(22000) - 2000, $urandom_range(1, 4),
                            $urandom_range(1, 3));
                 in_gaps_on = 1; out_stall_on = 1; end
        1: begin set_config(-32768, 1, 1023); in_gaps_on = 0; out_stall_on = 0; end
        2: begin set_config(32767, 1, 0); in_gaps_on = 1; out_stall_on = 1; end
        3: begin set_config($urandom_range(20000), 0, 1); in_gaps_on = 1; out_stall_on = 0; end
        4: begin set_config(int'($signed(16'($urandom))), $urandom_range(1, 6),
                            $urandom_range(1, 8));
                 in_gaps_on = 1; out_stall_on = 1; end
        default: begin set_config($urandom_range(16000), 2, 2);
                       in_gaps_on = 0; out_stall_on = 1; end
      endcase
      target = words_sent + 100;
      while (words_sent < target) send_random_frame();
    end
  endtask

  initial begin
    errors = 0;
    words_sent = 0;
    idle_cycles = 0;
    in_gaps_on = 1;
    out_stall_on = 1;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    sample_i = '0;
    row_end_i = 1'b0;
    frame_end_i = 1'b0;
    cfg_thresh = rprt_pkg::THRESH_RST;
    cfg_min_len = rprt_pkg::MIN_LEN_RST;
    cfg_jump = rprt_pkg::JUMP_RST;
    trk_row_max = '0;
    trk_row_col = '0;
    trk_col = '0;
    trk_row = '0;
    trk_row_started = 0;
    trk_open = 0;
    trk_start_row = '0;
    trk_start_col = '0;
    trk_prev_col = '0;
    trk_peak = '0;
    trk_sum = 0;
    trk_len = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_defaults();
    test_extremes();
    test_random();

    drain();
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
